### sv/sgcd_pkg.sv
// sgcd_pkg: shared types for the signed binary gcd block
// controller state encoding and the command and status groups between
// the controller and the datapath; no dependencies
package sgcd_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIP_COMMON,
        S_STRIP_A,
        S_REDUCE,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;          // capture operands of an accepted request
        logic strip_common;  // halve both values, count one common two
        logic strip_a;       // halve the first value
        logic reduce;        // one halving or compare-subtract step on b
        logic finish;        // form the result into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic zero_in;       // an operand of the request was zero
        logic both_even;     // both working values even
        logic a_even;        // first working value even
        logic b_zero;        // second working value reached zero
        logic out_free;      // output register can take a result
    } t_status;

endpackage

### sv/sgcd_ctrl.sv
// sgcd_ctrl: state machine that sequences the binary gcd datapath
// depends on sgcd_pkg for the state, command and status types
module sgcd_ctrl
    import sgcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_STRIP_COMMON;
                end
            end
            S_STRIP_COMMON: begin
                if (i_status.zero_in) begin
                    n_state = S_FINISH;
                end else if (!i_status.both_even) begin
                    n_state = S_STRIP_A;
                end
            end
            S_STRIP_A: begin
                if (!i_status.a_even) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.b_zero) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_STRIP_COMMON: begin
                o_cmd.strip_common = !i_status.zero_in && i_status.both_even;
            end
            S_STRIP_A: begin
                o_cmd.strip_a = i_status.a_even;
            end
            S_REDUCE: begin
                o_cmd.reduce = !i_status.b_zero;
            end
            S_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### sv/sgcd_datapath.sv
// sgcd_datapath: working registers, one-step reduce unit and output register
// depends on sgcd_pkg for the command and status types
module sgcd_datapath
    import sgcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [DATA_WIDTH-1:0] i_first_value,
    input  logic signed [DATA_WIDTH-1:0] i_second_value,
    input  logic                         i_out_ready,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    output logic                         o_out_valid,
    output logic signed [DATA_WIDTH-1:0] o_divisor
);

    localparam int TW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [TW-1:0]         r_twos;
    logic                  r_neg;
    logic                  r_zero;
    logic [DATA_WIDTH-1:0] r_divisor;
    logic                  r_out_valid;

    logic [DATA_WIDTH-1:0] mag_x;
    logic [DATA_WIDTH-1:0] mag_y;
    logic [DATA_WIDTH-1:0] g;
    logic [DATA_WIDTH-1:0] res;
    logic                  a_gt_b;

    // operand magnitudes, most negative value reads as 2^(w-1)
    assign mag_x = i_first_value[DATA_WIDTH-1]
                 ? ({DATA_WIDTH{1'b0}} - $unsigned(i_first_value))
                 : $unsigned(i_first_value);
    assign mag_y = i_second_value[DATA_WIDTH-1]
                 ? ({DATA_WIDTH{1'b0}} - $unsigned(i_second_value))
                 : $unsigned(i_second_value);

    assign a_gt_b = r_a > r_b;

    // shift the common twos back in and apply the sign rule
    assign g   = r_a << r_twos;
    assign res = r_zero ? {DATA_WIDTH{1'b0}}
               : (r_neg ? ({DATA_WIDTH{1'b0}} - g) : g);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= mag_x;
            r_b    <= mag_y;
            r_twos <= '0;
            r_neg  <= i_first_value[DATA_WIDTH-1] ^ i_second_value[DATA_WIDTH-1];
            r_zero <= (mag_x == '0) || (mag_y == '0);
        end else if (i_cmd.strip_common) begin
            r_a    <= r_a >> 1;
            r_b    <= r_b >> 1;
            r_twos <= r_twos + 1'b1;
        end else if (i_cmd.strip_a) begin
            r_a <= r_a >> 1;
        end else if (i_cmd.reduce) begin
            // b even: halve it; b odd: keep the smaller, subtract
            if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (a_gt_b) begin
                r_a <= r_b;
                r_b <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_divisor <= res;
        end
    end

    // status to controller
    assign o_status.zero_in   = r_zero;
    assign o_status.both_even = !(r_a[0] | r_b[0]);
    assign o_status.a_even    = !r_a[0];
    assign o_status.b_zero    = (r_b == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_divisor   = $signed(r_divisor);

endmodule

### sv/signed_binary_gcd_top.sv
// signed_binary_gcd_top: signed gcd by the binary method, one request at a time
// depends on sgcd_pkg, sgcd_ctrl and sgcd_datapath
//
// channel  direction  signals                       payload
// in       input      i_in_valid / o_in_ready       i_first_value, i_second_value
// out      output     o_out_valid / i_out_ready     o_divisor
//
// a request goes from idle through strip-common, strip-a and reduce to finish,
// with one strip-common step per common two and one strip-a step per further two
// of the first value; a zero operand goes from strip-common straight to finish;
// the reduce loop does one halving or one compare-subtract per cycle.
// i_rst_n is synchronous, active low; it clears the controller and output valid.
// a waiting result sits in the output register, so a new request is taken
// meanwhile; a stalled output holds only the finish step of the next one.
module signed_binary_gcd_top
    import sgcd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_first_value,
    input  logic signed [DATA_WIDTH-1:0] i_second_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_divisor
);

    t_cmd    cmd;
    t_status status;

    // controller
    sgcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath
    sgcd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_divisor      (o_divisor)
    );

    // one request in flight: no ready right after an accepted request
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // subtract steps only ever see an odd first value
    a_reduce_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.reduce |-> !status.a_even)
        else $error("reduce step with even first value");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("result overwrites a waiting result");

    // a zero operand gives a zero divisor
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish && status.zero_in) |=> (o_divisor == '0))
        else $error("zero operand gave nonzero divisor");

endmodule

### sim/sgcd_checker.sv
`timescale 1ns / 100ps
// sgcd_checker: watches the request and result channels of the signed gcd block,
// predicts each divisor and compares it with what comes out
// standalone, no package or rtl dependencies
module sgcd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_first_value,
    input  logic signed [DATA_WIDTH-1:0] i_second_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    // one predicted divisor, with the operands that gave it
    typedef struct {
        logic signed [DATA_WIDTH-1:0] first_value;
        logic signed [DATA_WIDTH-1:0] second_value;
        logic signed [DATA_WIDTH-1:0] divisor;
    } t_gcd_entry;

    t_gcd_entry predicted_divisors[$];
    int         mismatches  = 0;
    int         outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    // signed gcd by halving and subtraction on the magnitudes
    function automatic logic [DATA_WIDTH-1:0] signed_gcd(input logic [DATA_WIDTH-1:0] x,
                                                         input logic [DATA_WIDTH-1:0] y);
        logic [DATA_WIDTH-1:0] mag_x;
        logic [DATA_WIDTH-1:0] mag_y;
        logic [DATA_WIDTH-1:0] swap;
        logic [DATA_WIDTH-1:0] gcd_mag;
        int                    common_twos;
        mag_x = x[DATA_WIDTH-1] ? ('0 - x) : x;
        mag_y = y[DATA_WIDTH-1] ? ('0 - y) : y;
        if (mag_x == '0 || mag_y == '0)
            return '0;
        common_twos = 0;
        while (!mag_x[0] && !mag_y[0]) begin
            mag_x = mag_x >> 1;
            mag_y = mag_y >> 1;
            common_twos++;
        end
        while (!mag_x[0])
            mag_x = mag_x >> 1;
        // mag_x stays odd; mag_y is made odd and reduced by the smaller one
        while (mag_y != '0) begin
            while (!mag_y[0])
                mag_y = mag_y >> 1;
            if (mag_x > mag_y) begin
                swap  = mag_x;
                mag_x = mag_y;
                mag_y = swap;
            end
            mag_y = mag_y - mag_x;
        end
        gcd_mag = mag_x << common_twos;
        // opposite signs give a negative divisor
        if (x[DATA_WIDTH-1] != y[DATA_WIDTH-1])
            gcd_mag = '0 - gcd_mag;
        return gcd_mag;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t sgcd_checker: %s", $time, what);
        mismatches++;
    endtask

    // results are retired before new requests so a same-edge pair stays in order
    always @(posedge i_clk) begin
        t_gcd_entry entry;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_divisors.size() == 0) begin
                    report_mismatch($sformatf("divisor %0d with no request pending", i_divisor));
                end else begin
                    entry = predicted_divisors.pop_front();
                    outstanding--;
                    if (i_divisor !== entry.divisor)
                        report_mismatch($sformatf("gcd(%0d, %0d) gave %0d, predicted %0d",
                                                  entry.first_value, entry.second_value,
                                                  i_divisor, entry.divisor));
                end
            end
            if (i_in_valid && i_in_ready) begin
                entry.first_value  = i_first_value;
                entry.second_value = i_second_value;
                entry.divisor      = signed_gcd(i_first_value, i_second_value);
                predicted_divisors.insert(predicted_divisors.size(), entry);
                outstanding++;
            end
        end
    end

endmodule

### sim/signed_binary_gcd_top_tb.sv
`timescale 1ns / 100ps
// signed_binary_gcd_top_tb: request stimulus, result back-pressure and verdict
// for signed_binary_gcd_top; depends on the rtl and sgcd_checker
module signed_binary_gcd_top_tb;

    localparam int          W            = 32;
    localparam int unsigned MAG_MAX      = 32'h7fff_ffff;
    localparam int          RANDOM_ITEMS = 1880;
    localparam int          CALM_ITEMS   = 200;
    localparam int          DRAIN_CYCLES = 2 * W + 16;
    localparam int          TIMEOUT_NS   = 8_000_000;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic signed [W-1:0] i_first_value  = '0;
    logic signed [W-1:0] i_second_value = '0;
    logic                i_out_ready    = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic signed [W-1:0] o_divisor;

    int mismatches;
    int outstanding;
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_binary_gcd_top #(
        .DATA_WIDTH (W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_divisor      (o_divisor)
    );

    sgcd_checker #(
        .DATA_WIDTH (W)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_divisor      (o_divisor),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // result side back-pressure: stall bursts start at random, stall_pct percent of the time
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(input logic signed [W-1:0] first_op,
                                input logic signed [W-1:0] second_op);
        int gap;
        gap = (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_first_value  = first_op;
        i_second_value = second_op;
        i_in_valid     = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    // magnitude in range with a random sign
    function automatic logic signed [W-1:0] with_sign(input int unsigned mag);
        logic signed [W-1:0] val;
        val = mag;
        return $urandom_range(0, 1) ? -val : val;
    endfunction

    // full-width random operand, the most negative value excluded
    function automatic logic signed [W-1:0] any_operand();
        logic signed [W-1:0] val;
        val = $urandom;
        if (val == {1'b1, {(W-1){1'b0}}})
            val = -MAG_MAX;
        return val;
    endfunction

    // random operand pair drawn from a mix of shapes
    task automatic random_pair(output logic signed [W-1:0] first_op,
                               output logic signed [W-1:0] second_op);
        int unsigned factor;
        int unsigned shift_a;
        int unsigned shift_b;
        int          shape;
        shape = $urandom_range(0, 99);
        if (shape < 30) begin
            first_op  = any_operand();
            second_op = any_operand();
        end else if (shape < 55) begin
            // shared factor of random size
            factor    = $urandom_range(1, 1 << $urandom_range(1, 24));
            first_op  = with_sign(factor * $urandom_range(1, MAG_MAX / factor));
            second_op = with_sign(factor * $urandom_range(1, MAG_MAX / factor));
        end else if (shape < 70) begin
            // odd parts with powers of two, often common ones
            shift_a   = $urandom_range(0, 30);
            shift_b   = $urandom_range(0, 30);
            first_op  = with_sign(($urandom_range(0, MAG_MAX >> shift_a) | 1) << shift_a);
            second_op = with_sign(($urandom_range(0, MAG_MAX >> shift_b) | 1) << shift_b);
        end else if (shape < 85) begin
            first_op  = $signed($urandom_range(0, 128)) - 64;
            second_op = $signed($urandom_range(0, 128)) - 64;
        end else if (shape < 90) begin
            // zero, unit or extreme against anything
            case ($urandom_range(0, 2))
                0:       first_op = '0;
                1:       first_op = with_sign(1);
                default: first_op = with_sign(MAG_MAX);
            endcase
            second_op = any_operand();
            if ($urandom_range(0, 1)) begin
                first_op  ^= second_op;
                second_op ^= first_op;
                first_op  ^= second_op;
            end
        end else begin
            // one a multiple of the other
            factor    = $urandom_range(1, MAG_MAX >> $urandom_range(0, 30));
            first_op  = with_sign(factor);
            second_op = with_sign(factor * $urandom_range(1, MAG_MAX / factor));
        end
    endtask

    // stimulus and verdict
    initial begin
        logic signed [W-1:0] first_op;
        logic signed [W-1:0] second_op;
        int                  pct_choice[3];
        pct_choice = '{0, 15, 40};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zeros, units, extremes, sign combinations, powers of two
        send_request(0, 0);
        send_request(0, 5);
        send_request(7, 0);
        send_request(-MAG_MAX, 0);
        send_request(0, -MAG_MAX);
        send_request(1, 1);
        send_request(-1, 1);
        send_request(-1, -1);
        send_request(MAG_MAX, MAG_MAX);
        send_request(-MAG_MAX, -MAG_MAX);
        send_request(MAG_MAX, -MAG_MAX);
        send_request(MAG_MAX, MAG_MAX - 1);
        send_request(12, 18);
        send_request(-12, 18);
        send_request(12, -18);
        send_request(-12, -18);
        send_request(32'h4000_0000, 32'h2000_0000);
        send_request(-32'sh4000_0000, 32'h6000_0000);
        send_request(32'h4000_0000, 3);
        send_request(MAG_MAX, 1);
        send_request(-MAG_MAX, 32'h4000_0000);
        send_request(6, 6);

        // hold off until the directed results are all back
        wait_results_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                gap_pct   = pct_choice[$urandom_range(0, 2)];
                stall_pct = pct_choice[$urandom_range(0, 2)];
            end
            if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            if (n % 500 == 499)
                wait_results_drained();
            random_pair(first_op, second_op);
            send_request(first_op, second_op);
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("signed_binary_gcd_top_tb: PASS");
        else
            $display("signed_binary_gcd_top_tb: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("signed_binary_gcd_top_tb: FAIL");
        $finish;
    end

endmodule
